/* rtl/qlm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_pkg
// Shared types and constants for the queued lock manager: table sizes,
// command and status codes, channel payloads and the waiter table port.
// ----------------------------------------------------------------------------
package qlm_pkg;

    localparam int NUM_LOCKS      = 16;
    localparam int NUM_REQUESTERS = 8;
    localparam int LOCK_W         = $clog2(NUM_LOCKS);
    localparam int REQ_W          = $clog2(NUM_REQUESTERS);

    // Command codes. Bit 1 alone selects release, so code 3 also releases.
    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_TRY     = 2'd1;
    localparam int         CMD_REL_BIT = 1;

    localparam logic [2:0] STAT_GRANTED    = 3'd0;
    localparam logic [2:0] STAT_QUEUED     = 3'd1;
    localparam logic [2:0] STAT_TRY_FAILED = 3'd2;
    localparam logic [2:0] STAT_FREED      = 3'd3;
    localparam logic [2:0] STAT_HANDED     = 3'd4;
    localparam logic [2:0] STAT_NOT_HELD   = 3'd5;
    localparam logic [2:0] STAT_NOT_OWNER  = 3'd6;
    localparam logic [2:0] STAT_BUSY       = 3'd7;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] lock_index;
        logic [2:0] requester;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic       handoff_valid;
        logic [2:0] handoff_requester;
    } t_rsp;

    typedef struct packed {
        logic             held;
        logic [REQ_W-1:0] owner;
        logic [REQ_W-1:0] tail;
        logic             succ_valid;
        logic [REQ_W-1:0] succ;
    } t_lock_entry;

    // One access to the waiter table: an optional read and field writes.
    typedef struct packed {
        logic             rd;
        logic [REQ_W-1:0] addr;
        logic             wr_wait;
        logic             wait_val;
        logic             wr_link;
        logic             link_valid;
        logic [REQ_W-1:0] link;
    } t_wt_cmd;

    typedef struct packed {
        logic             waiting;
        logic             link_valid;
        logic [REQ_W-1:0] link;
    } t_wt_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVAL,
        ST_HAND,
        ST_LINK_TAIL,
        ST_LINK_REQ,
        ST_PUSH
    } t_state;

endpackage

/* rtl/qlm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_req_if / qlm_rsp_if
// Valid/ready channels carrying lock commands and their results.
// ----------------------------------------------------------------------------
interface qlm_req_if;
    import qlm_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface qlm_rsp_if;
    import qlm_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/qlm_waiter_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlm_waiter_table
// Per-requester queue state: waiting flag and link to the next waiter.
// Single access port, one access (a read and/or field writes) per cycle, registered read data.
// ----------------------------------------------------------------------------
module qlm_waiter_table
    import qlm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_wt_cmd i_cmd,
    output t_wt_rsp o_rsp
);

    logic             r_waiting    [NUM_REQUESTERS];
    logic             r_link_valid [NUM_REQUESTERS];
    logic [REQ_W-1:0] r_link       [NUM_REQUESTERS];
    t_wt_rsp          r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REQUESTERS; i++) begin
                r_waiting[i]    <= 1'b0;
                r_link_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.wr_wait) begin
                r_waiting[i_cmd.addr] <= i_cmd.wait_val;
            end
            if (i_cmd.wr_link) begin
                r_link_valid[i_cmd.addr] <= i_cmd.link_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_link) begin
            r_link[i_cmd.addr] <= i_cmd.link;
        end
        if (i_cmd.rd) begin
            r_rsp.waiting    <= r_waiting[i_cmd.addr];
            r_rsp.link_valid <= r_link_valid[i_cmd.addr];
            r_rsp.link       <= r_link[i_cmd.addr];
        end
    end

    assign o_rsp = r_rsp;

endmodule

/* rtl/queued_lock_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queued_lock_manager
// Lock table granting each lock in first-come order with per-lock queues.
// ----------------------------------------------------------------------------
// One command is processed at a time by a small sequencer around a single
// port waiter table. Grants, try failures, frees and errors go from ST_EVAL
// straight to ST_PUSH; a handoff passes through ST_HAND, queuing behind an
// owner with no waiters through ST_LINK_REQ, and queuing behind an existing
// waiter through ST_LINK_TAIL and ST_LINK_REQ; each extra state is one more
// access to the single-port waiter table. The input is ready again once the
// result is registered for output; an output stall holds the sequencer in
// ST_PUSH and so holds off the next command. A new command is taken as soon
// as the sequencer is back in idle, even if the previous result has not yet
// been transferred out.
module queued_lock_manager
    import qlm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    qlm_req_if.sink         i_req,
    qlm_rsp_if.source       o_rsp
);

    t_state           r_state, n_state;
    logic [1:0]       r_cmd;
    logic [LOCK_W-1:0] r_lk;
    logic [REQ_W-1:0] r_rq;
    logic [REQ_W-1:0] r_tgt, n_tgt;
    t_rsp             r_res, n_res;
    t_rsp             r_out;
    logic             r_out_valid;

    logic             r_held       [NUM_LOCKS];
    logic [REQ_W-1:0] r_owner      [NUM_LOCKS];
    logic [REQ_W-1:0] r_tail       [NUM_LOCKS];
    logic             r_succ_valid [NUM_LOCKS];
    logic [REQ_W-1:0] r_succ       [NUM_LOCKS];

    t_lock_entry      cur, n_entry;
    logic             lk_we;
    logic             owner_match;
    t_wt_cmd          wt_cmd;
    t_wt_rsp          wt_rsp;
    logic             accept;
    logic             push;

    qlm_waiter_table u_waiters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (wt_cmd),
        .o_rsp   (wt_rsp)
    );

    assign cur.held       = r_held[r_lk];
    assign cur.owner      = r_owner[r_lk];
    assign cur.tail       = r_tail[r_lk];
    assign cur.succ_valid = r_succ_valid[r_lk];
    assign cur.succ       = r_succ[r_lk];
    assign owner_match    = (cur.owner == r_rq);

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign push        = (r_state == ST_PUSH) && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_entry = cur;
        lk_we   = 1'b0;
        n_res   = r_res;
        n_tgt   = r_tgt;
        wt_cmd  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                wt_cmd.rd   = 1'b1;
                wt_cmd.addr = r_rq;
                n_state     = ST_EVAL;
            end
            ST_EVAL: begin
                n_res   = '{status: STAT_BUSY, handoff_valid: 1'b0, handoff_requester: '0};
                n_state = ST_PUSH;
                if (wt_rsp.waiting) begin
                    n_res.status = STAT_BUSY;
                end else if (r_cmd[CMD_REL_BIT]) begin
                    if (!cur.held) begin
                        n_res.status = STAT_NOT_HELD;
                    end else if (!owner_match) begin
                        n_res.status = STAT_NOT_OWNER;
                    end else if (!cur.succ_valid) begin
                        n_entry.held = 1'b0;
                        lk_we        = 1'b1;
                        n_res.status = STAT_FREED;
                    end else begin
                        // Fetch the first waiter's link before passing ownership.
                        wt_cmd.rd   = 1'b1;
                        wt_cmd.addr = cur.succ;
                        n_tgt       = cur.succ;
                        n_state     = ST_HAND;
                    end
                end else if (!cur.held) begin
                    n_entry.held       = 1'b1;
                    n_entry.owner      = r_rq;
                    n_entry.tail       = r_rq;
                    n_entry.succ_valid = 1'b0;
                    lk_we              = 1'b1;
                    n_res.status       = STAT_GRANTED;
                end else if (r_cmd == CMD_TRY) begin
                    n_res.status = STAT_TRY_FAILED;
                end else if (owner_match) begin
                    n_res.status = STAT_BUSY;
                end else begin
                    n_entry.tail = r_rq;
                    lk_we        = 1'b1;
                    n_tgt        = cur.tail;
                    if (!cur.succ_valid) begin
                        n_entry.succ_valid = 1'b1;
                        n_entry.succ       = r_rq;
                        n_state            = ST_LINK_REQ;
                    end else begin
                        n_state = ST_LINK_TAIL;
                    end
                end
            end
            ST_HAND: begin
                n_entry.owner      = r_tgt;
                n_entry.succ_valid = wt_rsp.link_valid;
                n_entry.succ       = wt_rsp.link;
                lk_we              = 1'b1;
                wt_cmd.addr        = r_tgt;
                wt_cmd.wr_wait     = 1'b1;
                wt_cmd.wait_val    = 1'b0;
                wt_cmd.wr_link     = 1'b1;
                wt_cmd.link_valid  = 1'b0;
                n_res = '{status: STAT_HANDED, handoff_valid: 1'b1,
                          handoff_requester: r_tgt};
                n_state = ST_PUSH;
            end
            ST_LINK_TAIL: begin
                wt_cmd.addr       = r_tgt;
                wt_cmd.wr_link    = 1'b1;
                wt_cmd.link_valid = 1'b1;
                wt_cmd.link       = r_rq;
                n_state           = ST_LINK_REQ;
            end
            ST_LINK_REQ: begin
                wt_cmd.addr       = r_rq;
                wt_cmd.wr_wait    = 1'b1;
                wt_cmd.wait_val   = 1'b1;
                wt_cmd.wr_link    = 1'b1;
                wt_cmd.link_valid = 1'b0;
                n_res = '{status: STAT_QUEUED, handoff_valid: 1'b0, handoff_requester: '0};
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (push) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LOCKS; i++) begin
                r_held[i]       <= 1'b0;
                r_succ_valid[i] <= 1'b0;
            end
        end else if (lk_we) begin
            r_held[r_lk]       <= n_entry.held;
            r_succ_valid[r_lk] <= n_entry.succ_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            r_owner[r_lk] <= n_entry.owner;
            r_tail[r_lk]  <= n_entry.tail;
            r_succ[r_lk]  <= n_entry.succ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_req.payload.command;
            r_lk  <= i_req.payload.lock_index[LOCK_W-1:0];
            r_rq  <= i_req.payload.requester[REQ_W-1:0];
        end
        r_tgt <= n_tgt;
        r_res <= n_res;
        if (push) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // A handoff is reported exactly when the status says the lock was handed over.
    a_handoff_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.payload.handoff_valid == (o_rsp.payload.status == STAT_HANDED)))
        else $error("handoff flag disagrees with status");

    // A free lock never keeps a queue behind it.
    a_free_no_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) && !cur.held |-> !cur.succ_valid)
        else $error("free lock still has a waiter");

    // The waiter that receives a lock must have been queued.
    a_hand_to_waiter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HAND) |-> wt_rsp.waiting)
        else $error("lock handed to a requester that was not waiting");

endmodule
